// ----- hdl/qjrs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qjrs_pkg
// Shared types and constants of the quaternion julia ray search unit.
// ---------------------------------------------------------------------------
package qjrs_pkg;

    // fixed point format
    localparam int Q_FRAC   = 24;
    localparam int N_W      = 44;
    localparam int SQS_W    = 59;
    localparam int DIV_W    = 33;
    localparam int MAG_W    = 33;
    localparam int CNT_W    = 12;

    // escape limits: |component| > 10 and squared norm > 100
    localparam logic signed [N_W-1:0] ESC_LIM = N_W'(64'sd10 <<< Q_FRAC);
    localparam logic [SQS_W-1:0] ESC_SQ = SQS_W'(64'd100 << (2 * Q_FRAC));

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_C_REAL     = 3'd0,
        CFG_C_I        = 3'd1,
        CFG_C_J        = 3'd2,
        CFG_C_K        = 3'd3,
        CFG_SAMPLES    = 3'd4,
        CFG_PRECISION  = 3'd5,
        CFG_ITER_LIMIT = 3'd6
    } t_cfg_idx;

    // input word
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } t_item_in;

    // result word
    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_item_out;

    // live configuration
    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_i;
        logic signed [31:0] c_j;
        logic signed [31:0] c_k;
        logic [CNT_W-1:0]   m;
        logic [30:0]        precision;
        logic [9:0]         iter_limit;
    } t_cfg;

    // classified ray: start point, step quotient and remainder per axis
    typedef struct packed {
        logic [2:0][31:0]      s;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] qd;
        logic [2:0][CNT_W-1:0] rd;
    } t_ray;

    // iteration unit response
    typedef struct packed {
        logic done;
        logic in_set;
    } t_iter_rsp;

    typedef enum logic [2:0] {
        IT_IDLE,
        IT_SQR,
        IT_CROSS,
        IT_NEXT,
        IT_CHECK,
        IT_NORM
    } t_iter_st;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SAMPLE,
        BK_SGO,
        BK_SWAIT,
        BK_LOWER,
        BK_DIFF,
        BK_SQR,
        BK_CMP,
        BK_BGO,
        BK_BWAIT,
        BK_DONE
    } t_back_st;

endpackage

// ----- hdl/qjrs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qjrs_front
// Takes ray words, works out the per-sample step as quotient and remainder
// with a bit-serial divider per axis, and queues the result for the back end.
// ---------------------------------------------------------------------------
module qjrs_front
    import qjrs_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    output logic              o_full,
    input  t_item_in          i_item,
    input  wire [CNT_W-1:0]   i_m,
    output logic              o_ray_valid,
    input  wire               i_ray_take,
    output t_ray              o_ray
);

    localparam int QD = 2;

    logic                  r_busy;
    logic [5:0]            r_cnt;
    logic [CNT_W-1:0]      r_rem [3];
    logic [DIV_W-1:0]      r_quo [3];
    logic [31:0]           r_s   [3];
    logic [2:0]            r_neg;

    t_ray                  r_q [QD];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_qn;

    logic                  w_div_done;
    logic                  w_qpush;
    logic                  w_qpop;
    logic signed [32:0]    w_d   [3];
    logic [CNT_W:0]        w_sh  [3];
    logic                  w_ge  [3];
    logic [31:0]           w_in_s [3];
    logic [31:0]           w_in_e [3];

    assign w_in_s[0] = i_item.start_x;
    assign w_in_s[1] = i_item.start_y;
    assign w_in_s[2] = i_item.start_z;
    assign w_in_e[0] = i_item.end_x;
    assign w_in_e[1] = i_item.end_y;
    assign w_in_e[2] = i_item.end_z;

    assign o_full      = r_busy;
    assign w_div_done  = r_busy && (r_cnt == 6'(DIV_W));
    assign w_qpush     = w_div_done && (r_qn != 2'(QD));
    assign o_ray_valid = (r_qn != 2'd0);
    assign w_qpop      = o_ray_valid && i_ray_take;
    assign o_ray       = r_q[r_rp];

    // axis difference and one restoring divide step per axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]  = $signed({w_in_e[k][31], w_in_e[k]}) - $signed({w_in_s[k][31], w_in_s[k]});
            w_sh[k] = {r_rem[k], r_quo[k][DIV_W-1]};
            w_ge[k] = (w_sh[k] >= {1'b0, i_m});
        end
    end

    // divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (!r_busy) begin
            if (i_push) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end
        end else if (!w_div_done) begin
            r_cnt <= r_cnt + 6'd1;
        end else if (w_qpush) begin
            r_busy <= 1'b0;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (!r_busy && i_push) begin
                r_s[k]   <= w_in_s[k];
                r_neg[k] <= w_d[k][32];
                r_quo[k] <= w_d[k][32] ? DIV_W'(-w_d[k]) : DIV_W'(w_d[k]);
                r_rem[k] <= '0;
            end else if (r_busy && !w_div_done) begin
                r_rem[k] <= w_ge[k] ? CNT_W'(w_sh[k] - {1'b0, i_m}) : w_sh[k][CNT_W-1:0];
                r_quo[k] <= {r_quo[k][DIV_W-2:0], w_ge[k]};
            end
        end
    end

    // two-entry queue towards the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_qn <= 2'd0;
        end else begin
            if (w_qpush) r_wp <= ~r_wp;
            if (w_qpop)  r_rp <= ~r_rp;
            if (w_qpush && !w_qpop)      r_qn <= r_qn + 2'd1;
            else if (!w_qpush && w_qpop) r_qn <= r_qn - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_qpush) begin
            for (int k = 0; k < 3; k++) begin
                r_q[r_wp].s[k]   <= r_s[k];
                r_q[r_wp].neg[k] <= r_neg[k];
                r_q[r_wp].qd[k]  <= r_quo[k];
                r_q[r_wp].rd[k]  <= r_rem[k];
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/qjrs_iter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qjrs_iter
// Escape-time test of one point: q = q*q + c on a four-lane multiplier,
// stepping through the square, cross, next, check and norm states.
// ---------------------------------------------------------------------------
module qjrs_iter
    import qjrs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [2:0][31:0]  i_pt,
    input  t_cfg             i_cfg,
    output t_iter_rsp        o_rsp
);

    t_iter_st                 r_st;
    t_iter_st                 n_st;
    logic signed [31:0]       r_a, r_b, r_c, r_d;
    logic [9:0]               r_it;
    logic signed [63:0]       r_p [4];
    logic signed [N_W-1:0]    r_n [4];
    logic                     r_done;
    logic                     r_inside;

    logic signed [31:0]       w_ma [4];
    logic signed [31:0]       w_mb [4];
    logic signed [N_W-1:0]    w_na;
    logic signed [N_W-1:0]    w_cr [4];
    logic                     w_esc;
    logic [SQS_W-1:0]         w_sum;
    logic                     w_last;

    assign o_rsp.done   = r_done;
    assign o_rsp.in_set = r_inside;

    // component sums
    assign w_na = N_W'(r_p[0] >>> Q_FRAC) - N_W'(r_p[1] >>> Q_FRAC)
                - N_W'(r_p[2] >>> Q_FRAC) - N_W'(r_p[3] >>> Q_FRAC)
                + N_W'(i_cfg.c_real);
    assign w_cr[0] = '0;
    assign w_cr[1] = N_W'(r_p[0] >>> (Q_FRAC - 1)) + N_W'(i_cfg.c_i);
    assign w_cr[2] = N_W'(r_p[1] >>> (Q_FRAC - 1)) + N_W'(i_cfg.c_j);
    assign w_cr[3] = N_W'(r_p[2] >>> (Q_FRAC - 1)) + N_W'(i_cfg.c_k);

    // escape tests
    always_comb begin
        w_esc = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (r_n[k] > ESC_LIM || r_n[k] < -ESC_LIM) w_esc = 1'b1;
        end
    end
    assign w_sum  = SQS_W'(r_p[0]) + SQS_W'(r_p[1]) + SQS_W'(r_p[2]) + SQS_W'(r_p[3]);
    assign w_last = (10'(r_it + 10'd1) == i_cfg.iter_limit);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            IT_IDLE:  if (i_start && i_cfg.iter_limit != 10'd0) n_st = IT_SQR;
            IT_SQR:   n_st = IT_CROSS;
            IT_CROSS: n_st = IT_NEXT;
            IT_NEXT:  n_st = IT_CHECK;
            IT_CHECK: n_st = w_esc ? IT_IDLE : IT_NORM;
            IT_NORM:  n_st = (w_sum > ESC_SQ || w_last) ? IT_IDLE : IT_SQR;
            default:  n_st = IT_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_ma[k] = '0;
            w_mb[k] = '0;
        end
        case (r_st)
            IT_SQR: begin
                w_ma[0] = r_a; w_mb[0] = r_a;
                w_ma[1] = r_b; w_mb[1] = r_b;
                w_ma[2] = r_c; w_mb[2] = r_c;
                w_ma[3] = r_d; w_mb[3] = r_d;
            end
            IT_CROSS: begin
                w_ma[0] = r_a; w_mb[0] = r_b;
                w_ma[1] = r_a; w_mb[1] = r_c;
                w_ma[2] = r_a; w_mb[2] = r_d;
            end
            IT_CHECK: begin
                for (int k = 0; k < 4; k++) begin
                    w_ma[k] = r_n[k][31:0];
                    w_mb[k] = r_n[k][31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= IT_IDLE;
        else          r_st <= n_st;
    end

    // response flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                IT_IDLE: if (i_start && i_cfg.iter_limit == 10'd0) begin
                    r_done   <= 1'b1;
                    r_inside <= 1'b1;
                end
                IT_CHECK: if (w_esc) begin
                    r_done   <= 1'b1;
                    r_inside <= 1'b0;
                end
                IT_NORM: if (w_sum > ESC_SQ) begin
                    r_done   <= 1'b1;
                    r_inside <= 1'b0;
                end else if (w_last) begin
                    r_done   <= 1'b1;
                    r_inside <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) r_p[k] <= w_ma[k] * w_mb[k];
        case (r_st)
            IT_IDLE: if (i_start) begin
                r_a  <= $signed(i_pt[0]);
                r_b  <= $signed(i_pt[1]);
                r_c  <= $signed(i_pt[2]);
                r_d  <= '0;
                r_it <= '0;
            end
            IT_CROSS: r_n[0] <= w_na;
            IT_NEXT: begin
                r_n[1] <= w_cr[1];
                r_n[2] <= w_cr[2];
                r_n[3] <= w_cr[3];
            end
            IT_NORM: begin
                r_a  <= r_n[0][31:0];
                r_b  <= r_n[1][31:0];
                r_c  <= r_n[2][31:0];
                r_d  <= r_n[3][31:0];
                r_it <= 10'(r_it + 10'd1);
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/qjrs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qjrs_back
// Walks the coarse samples of a queued ray, then bisects the first inside
// sample against the one before it, using the shared iteration unit.
// ---------------------------------------------------------------------------
module qjrs_back
    import qjrs_pkg::*;
#(
    parameter int MAX_BISECT_STEPS = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cfg             i_cfg,
    input  wire              i_ray_valid,
    output logic             o_ray_take,
    input  t_ray             i_ray,
    output logic             o_start,
    output logic [2:0][31:0] o_pt,
    input  t_iter_rsp        i_rsp,
    output logic             o_res_valid,
    input  wire              i_res_ready,
    output t_item_out        o_res
);

    localparam int SW = $clog2(MAX_BISECT_STEPS + 1);

    t_back_st               r_st;
    t_back_st               n_st;
    t_ray                   r_ray;
    logic [MAG_W-1:0]       r_qa [3];
    logic [CNT_W-1:0]       r_ra [3];
    logic [CNT_W-1:0]       r_i;
    logic [SW-1:0]          r_step;
    logic [31:0]            r_u  [3];
    logic [31:0]            r_l  [3];
    logic [31:0]            r_pt [3];
    logic [30:0]            r_adf [3];
    logic                   r_big;
    logic [61:0]            r_sq [3];
    logic [61:0]            r_psq;
    t_item_out              r_res;

    logic [33:0]            w_smp [3];
    logic [33:0]            w_ext [3];
    logic [31:0]            w_sat [3];
    logic [CNT_W:0]         w_rn  [3];
    logic                   w_wrap [3];
    logic [32:0]            w_msum [3];
    logic [32:0]            w_df  [3];
    logic [32:0]            w_ad  [3];
    logic                   w_big;
    logic [63:0]            w_ssum;
    logic                   w_apart;
    logic                   w_stop;

    // sample, extrapolated lower bound, step advance, midpoint, distance
    always_comb begin
        w_big = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_smp[k] = {{2{r_ray.s[k][31]}}, r_ray.s[k]}
                     + (r_ray.neg[k] ? -{1'b0, r_qa[k]} : {1'b0, r_qa[k]});
            w_ext[k] = {{2{r_ray.s[k][31]}}, r_ray.s[k]}
                     - (r_ray.neg[k] ? -{1'b0, r_ray.qd[k]} : {1'b0, r_ray.qd[k]});
            if (w_ext[k][33:31] == 3'b000 || w_ext[k][33:31] == 3'b111)
                w_sat[k] = w_ext[k][31:0];
            else
                w_sat[k] = w_ext[k][33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            w_rn[k]   = {1'b0, r_ra[k]} + {1'b0, r_ray.rd[k]};
            w_wrap[k] = (w_rn[k] >= {1'b0, i_cfg.m});
            w_msum[k] = {r_u[k][31], r_u[k]} + {r_l[k][31], r_l[k]};
            w_df[k]   = {r_u[k][31], r_u[k]} - {r_l[k][31], r_l[k]};
            w_ad[k]   = w_df[k][32] ? -w_df[k] : w_df[k];
            if (w_ad[k] > {2'b00, i_cfg.precision}) w_big = 1'b1;
        end
    end

    assign w_ssum  = 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
    assign w_apart = r_big || (w_ssum > 64'(r_psq));
    assign w_stop  = (r_step == SW'(MAX_BISECT_STEPS)) || !w_apart;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE:   if (i_ray_valid) n_st = BK_SAMPLE;
            BK_SAMPLE: n_st = BK_SGO;
            BK_SGO:    n_st = BK_SWAIT;
            BK_SWAIT:  if (i_rsp.done) begin
                if (i_rsp.in_set)        n_st = BK_LOWER;
                else if (r_i == i_cfg.m) n_st = BK_DONE;
                else                     n_st = BK_SAMPLE;
            end
            BK_LOWER:  n_st = BK_DIFF;
            BK_DIFF:   n_st = BK_SQR;
            BK_SQR:    n_st = BK_CMP;
            BK_CMP:    n_st = w_stop ? BK_DONE : BK_BGO;
            BK_BGO:    n_st = BK_BWAIT;
            BK_BWAIT:  if (i_rsp.done) n_st = BK_DIFF;
            BK_DONE:   if (i_res_ready) n_st = BK_IDLE;
            default:   n_st = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ray_take  = (r_st == BK_IDLE) && i_ray_valid;
        o_start     = (r_st == BK_SGO) || (r_st == BK_BGO);
        o_res_valid = (r_st == BK_DONE);
        o_res       = r_res;
        for (int k = 0; k < 3; k++) o_pt[k] = r_pt[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= BK_IDLE;
        else          r_st <= n_st;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            BK_IDLE: if (i_ray_valid) begin
                r_ray <= i_ray;
                r_i   <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_qa[k] <= '0;
                    r_ra[k] <= '0;
                end
            end
            BK_SAMPLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_u[k]  <= w_smp[k][31:0];
                    r_pt[k] <= w_smp[k][31:0];
                end
            end
            BK_SWAIT: if (i_rsp.done) begin
                if (!i_rsp.in_set && r_i == i_cfg.m) begin
                    r_res <= '0;
                end else if (!i_rsp.in_set) begin
                    r_i <= r_i + CNT_W'(1);
                    for (int k = 0; k < 3; k++) begin
                        r_l[k]  <= r_u[k];
                        r_ra[k] <= w_wrap[k] ? CNT_W'(w_rn[k] - {1'b0, i_cfg.m})
                                             : w_rn[k][CNT_W-1:0];
                        r_qa[k] <= r_qa[k] + r_ray.qd[k] + MAG_W'(w_wrap[k]);
                    end
                end
            end
            BK_LOWER: begin
                r_step <= '0;
                if (r_i == '0) begin
                    for (int k = 0; k < 3; k++) r_l[k] <= w_sat[k];
                end
            end
            BK_DIFF: begin
                r_big <= w_big;
                for (int k = 0; k < 3; k++) r_adf[k] <= w_ad[k][30:0];
            end
            BK_SQR: begin
                r_psq <= i_cfg.precision * i_cfg.precision;
                for (int k = 0; k < 3; k++) r_sq[k] <= r_adf[k] * r_adf[k];
            end
            BK_CMP: begin
                if (w_stop) begin
                    r_res.hit     <= 1'b1;
                    r_res.point_x <= w_msum[0][32:1];
                    r_res.point_y <= w_msum[1][32:1];
                    r_res.point_z <= w_msum[2][32:1];
                end else begin
                    for (int k = 0; k < 3; k++) r_pt[k] <= w_msum[k][32:1];
                end
            end
            BK_BWAIT: if (i_rsp.done) begin
                r_step <= r_step + SW'(1);
                for (int k = 0; k < 3; k++) begin
                    if (i_rsp.in_set) r_u[k] <= r_pt[k];
                    else              r_l[k] <= r_pt[k];
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/quaternion_julia_ray_search_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quaternion_julia_ray_search_unit
// Searches a ray segment for the first point of a quaternion julia set.
//
// Each ray word gives one result word, in order. A ray is first divided into
// per-sample steps (overlapped with the previous ray's search), then samples
// are tested one after another on a single iteration unit with four 32x32
// multipliers; a hit adds a bisection, and rays whose points escape early
// finish sooner. Up to two classified rays and one finished result are
// buffered, so input and output stall independently.
// ---------------------------------------------------------------------------
module quaternion_julia_ray_search_unit
    import qjrs_pkg::*;
#(
    parameter int MAX_BISECT_STEPS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  t_item_in   i_item,
    output logic       empty,
    input  wire        pop,
    output t_item_out  o_item,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data
);

    logic [31:0]  r_c [4];
    logic [11:0]  r_samples;
    logic [30:0]  r_prec;
    logic [9:0]   r_limit;
    logic         r_out_valid;
    t_item_out    r_out;

    t_cfg         w_cfg;
    logic         w_ray_valid;
    logic         w_ray_take;
    t_ray         w_ray;
    logic         w_start;
    logic [2:0][31:0] w_pt;
    t_iter_rsp    w_rsp;
    logic         w_res_valid;
    logic         w_res_ready;
    t_item_out    w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_c[k] <= '0;
            r_samples <= 12'd64;
            r_prec    <= 31'd16777;
            r_limit   <= 10'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_C_REAL:     r_c[0]    <= i_cfg_data;
                CFG_C_I:        r_c[1]    <= i_cfg_data;
                CFG_C_J:        r_c[2]    <= i_cfg_data;
                CFG_C_K:        r_c[3]    <= i_cfg_data;
                CFG_SAMPLES:    r_samples <= i_cfg_data[11:0];
                CFG_PRECISION:  r_prec    <= i_cfg_data[30:0];
                CFG_ITER_LIMIT: r_limit   <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // sample spacing divisor, at least one
    always_comb begin
        w_cfg.c_real     = r_c[0];
        w_cfg.c_i        = r_c[1];
        w_cfg.c_j        = r_c[2];
        w_cfg.c_k        = r_c[3];
        w_cfg.m          = (r_samples < 12'd2) ? 12'd1 : 12'(r_samples - 12'd1);
        w_cfg.precision  = r_prec;
        w_cfg.iter_limit = r_limit;
    end

    qjrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_m         (w_cfg.m),
        .o_ray_valid (w_ray_valid),
        .i_ray_take  (w_ray_take),
        .o_ray       (w_ray)
    );

    qjrs_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_pt    (w_pt),
        .i_cfg   (w_cfg),
        .o_rsp   (w_rsp)
    );

    qjrs_back #(
        .MAX_BISECT_STEPS (MAX_BISECT_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_ray_valid (w_ray_valid),
        .o_ray_take  (w_ray_take),
        .i_ray       (w_ray),
        .o_start     (w_start),
        .o_pt        (w_pt),
        .i_rsp       (w_rsp),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // result register
    assign w_res_ready = !r_out_valid || pop;
    assign empty       = !r_out_valid;
    assign o_item      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) r_out <= w_res;
    end

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result overwritten");
    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> !empty)
        else $error("finished result lost");
`endif

endmodule
`default_nettype wire
